>>> hw/rtl/lsci_pkg.sv
// ----------------------------------------------------------------------------
// lsci_pkg
// Widths, stage map and sideband types for the segment/circle crossing pipe.
// ----------------------------------------------------------------------------
package lsci_pkg;

    localparam int CW    = 32;          // coordinate width
    localparam int RADW  = CW - 1;      // radius width
    localparam int DW    = CW + 1;      // coordinate difference
    localparam int PROD  = 2 * DW;      // 33x33 product
    localparam int SUMW  = PROD;        // a, h, |c|
    localparam int CWID  = SUMW + 1;    // signed c
    localparam int HALF  = 33;          // split point of 66-bit operands
    localparam int DW2   = 2 * SUMW;    // discriminant magnitude
    localparam int DISW  = DW2 + 2;     // signed discriminant
    localparam int SQN   = SUMW;        // root bits, one per stage
    localparam int SQRW  = SQN + 2;     // root remainder
    localparam int NW    = SQN + 2;     // signed root numerator
    localparam int NMAG  = NW - 1;      // numerator magnitude
    localparam int NLO   = 34;          // low slice of numerator
    localparam int NHI   = NMAG - NLO;  // high slice of numerator
    localparam int MW    = 101;         // rounded product magnitude
    localparam int QB    = 36;          // quotient bits, one per stage
    localparam int DRW   = SUMW;        // divider remainder
    localparam int NLANE = 4;
    localparam int QSW   = QB + 1;      // signed quotient
    localparam int SSW   = QB + 2;      // start point plus quotient

    // stage map
    localparam int ST_SQ0  = 6;
    localparam int ST_N    = ST_SQ0 + SQN;
    localparam int ST_DIV0 = ST_N + 4;
    localparam int ST_OUT  = ST_DIV0 + QB;
    localparam int NST     = ST_OUT + 1;

    typedef struct packed {
        logic signed [CW-1:0]   x0;
        logic signed [CW-1:0]   y0;
        logic signed [DW-1:0]   dx;
        logic signed [DW-1:0]   dy;
        logic [SUMW-1:0]        a;
        logic signed [SUMW-1:0] h;
        logic                   degen;
        logic                   neg;
    } sq_side_t;

    typedef struct packed {
        logic signed [CW-1:0]   x0;
        logic signed [CW-1:0]   y0;
        logic [SUMW-1:0]        a;
        logic [NLANE-1:0]       sgn;
        logic                   v1;
        logic                   v2;
        logic                   degen;
        logic                   neg;
    } div_side_t;

endpackage

>>> hw/rtl/lsci_sqrt.sv
// ----------------------------------------------------------------------------
// lsci_sqrt
// Pipelined floor square root of the discriminant, one root bit per stage.
// ----------------------------------------------------------------------------
module lsci_sqrt
    import lsci_pkg::*;
(
    input  logic             clk,
    input  logic [SQN-1:0]   en,
    input  logic [DW2-1:0]   rad,
    input  sq_side_t         side_in,
    output logic [SQN-1:0]   root,
    output sq_side_t         side_out
);

    logic [DW2-1:0]  dsh_reg  [SQN];
    logic [SQRW-1:0] rem_reg  [SQN];
    logic [SQN-1:0]  root_reg [SQN];
    sq_side_t        side_reg [SQN];

    logic [DW2-1:0]  dsh_next  [SQN];
    logic [SQRW-1:0] rem_next  [SQN];
    logic [SQN-1:0]  root_next [SQN];
    sq_side_t        side_next [SQN];

    always_comb
    begin
        logic [DW2-1:0]  dp;
        logic [SQRW-1:0] rp;
        logic [SQN-1:0]  qp;
        logic [SQRW+1:0] cur;
        logic [SQRW+1:0] trial;
        for (int k = 0; k < SQN; k++)
        begin
            if (k == 0)
            begin
                dp           = rad;
                rp           = '0;
                qp           = '0;
                side_next[k] = side_in;
            end
            else
            begin
                dp           = dsh_reg[k-1];
                rp           = rem_reg[k-1];
                qp           = root_reg[k-1];
                side_next[k] = side_reg[k-1];
            end
            cur   = {rp, dp[DW2-1 -: 2]};
            trial = {{(SQRW-SQN){1'b0}}, qp, 2'b01};
            dsh_next[k] = dp << 2;
            if (cur >= trial)
            begin
                rem_next[k]  = SQRW'(cur - trial);
                root_next[k] = {qp[SQN-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = cur[SQRW-1:0];
                root_next[k] = {qp[SQN-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SQN; k++)
        begin
            if (en[k])
            begin
                dsh_reg[k]  <= dsh_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    assign root     = root_reg[SQN-1];
    assign side_out = side_reg[SQN-1];

endmodule

>>> hw/rtl/lsci_div.sv
// ----------------------------------------------------------------------------
// lsci_div
// Four-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lsci_div
    import lsci_pkg::*;
(
    input  logic            clk,
    input  logic [QB-1:0]   en,
    input  logic [MW-1:0]   m    [NLANE],
    input  div_side_t       side_in,
    output logic [QB-1:0]   quo  [NLANE],
    output div_side_t       side_out
);

    logic [DRW-1:0] rem_reg  [QB][NLANE];
    logic [QB-1:0]  sh_reg   [QB][NLANE];
    div_side_t      side_reg [QB];

    logic [DRW-1:0] rem_next  [QB][NLANE];
    logic [QB-1:0]  sh_next   [QB][NLANE];
    div_side_t      side_next [QB];

    always_comb
    begin
        logic [DRW-1:0] rp;
        logic [QB-1:0]  sp;
        logic [DRW:0]   trial;
        logic [DRW:0]   aext;
        for (int k = 0; k < QB; k++)
        begin
            side_next[k] = (k == 0) ? side_in : side_reg[k-1];
            aext = {1'b0, side_next[k].a};
            for (int l = 0; l < NLANE; l++)
            begin
                if (k == 0)
                begin
                    rp = DRW'(m[l][MW-1:QB]);
                    sp = m[l][QB-1:0];
                end
                else
                begin
                    rp = rem_reg[k-1][l];
                    sp = sh_reg[k-1][l];
                end
                trial = {rp, sp[QB-1]};
                if (trial >= aext)
                begin
                    rem_next[k][l] = DRW'(trial - aext);
                    sh_next[k][l]  = {sp[QB-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k][l] = trial[DRW-1:0];
                    sh_next[k][l]  = {sp[QB-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < QB; k++)
        begin
            if (en[k])
            begin
                side_reg[k] <= side_next[k];
                for (int l = 0; l < NLANE; l++)
                begin
                    rem_reg[k][l] <= rem_next[k][l];
                    sh_reg[k][l]  <= sh_next[k][l];
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < NLANE; l++)
        begin
            quo[l] = sh_reg[QB-1][l];
        end
    end

    assign side_out = side_reg[QB-1];

endmodule

>>> hw/rtl/line_segment_circle_intersect.sv
// ----------------------------------------------------------------------------
// line_segment_circle_intersect
// Segment against circle crossing points, fully pipelined.
//
//   channel  handshake                   payload
//   item     item_valid / item_ready     segment ends, centre, radius
//   result   result_valid / result_ready two points, valid flags, degenerate
//
// One item per cycle while result_ready holds; 66 root stages, 36
// quotient stages, 11 arithmetic and output stages.
// Reset clears only the stage valid bits.
// A stage holds while the one after it is full and stalled; empty stages
// keep filling, so input is taken until the pipe is full.
// ----------------------------------------------------------------------------
module line_segment_circle_intersect
    import lsci_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic signed [CW-1:0] seg_start_x,
    input  logic signed [CW-1:0] seg_start_y,
    input  logic signed [CW-1:0] seg_end_x,
    input  logic signed [CW-1:0] seg_end_y,
    input  logic signed [CW-1:0] center_x,
    input  logic signed [CW-1:0] center_y,
    input  logic [RADW-1:0]      radius,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic                 first_valid,
    output logic signed [CW-1:0] first_x,
    output logic signed [CW-1:0] first_y,
    output logic                 second_valid,
    output logic signed [CW-1:0] second_x,
    output logic signed [CW-1:0] second_y,
    output logic                 degenerate
);

    logic [NST-1:0] v_reg;
    logic [NST-1:0] v_in;
    logic [NST-1:0] en;

    // stall chain: a stage moves when empty or when its successor moves
    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || result_ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign v_in = {v_reg[NST-2:0], item_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_in[k];
                end
            end
        end
    end

    assign item_ready   = en[0];
    assign result_valid = v_reg[NST-1];

    // stage 0: differences
    logic signed [CW-1:0] s0_x0_reg, s0_y0_reg;
    logic signed [DW-1:0] s0_sx_reg, s0_sy_reg, s0_dx_reg, s0_dy_reg;
    logic [RADW-1:0]      s0_r_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_x0_reg <= seg_start_x;
            s0_y0_reg <= seg_start_y;
            s0_sx_reg <= {seg_start_x[CW-1], seg_start_x} - {center_x[CW-1], center_x};
            s0_sy_reg <= {seg_start_y[CW-1], seg_start_y} - {center_y[CW-1], center_y};
            s0_dx_reg <= {seg_end_x[CW-1], seg_end_x} - {seg_start_x[CW-1], seg_start_x};
            s0_dy_reg <= {seg_end_y[CW-1], seg_end_y} - {seg_start_y[CW-1], seg_start_y};
            s0_r_reg  <= radius;
        end
    end

    // stage 1: products
    logic signed [PROD-1:0] s1_ddx_reg, s1_ddy_reg, s1_dsx_reg, s1_dsy_reg;
    logic signed [PROD-1:0] s1_ssx_reg, s1_ssy_reg;
    logic [2*RADW-1:0]      s1_rr_reg;
    logic signed [CW-1:0]   s1_x0_reg, s1_y0_reg;
    logic signed [DW-1:0]   s1_dx_reg, s1_dy_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_ddx_reg <= PROD'(s0_dx_reg) * PROD'(s0_dx_reg);
            s1_ddy_reg <= PROD'(s0_dy_reg) * PROD'(s0_dy_reg);
            s1_dsx_reg <= PROD'(s0_dx_reg) * PROD'(s0_sx_reg);
            s1_dsy_reg <= PROD'(s0_dy_reg) * PROD'(s0_sy_reg);
            s1_ssx_reg <= PROD'(s0_sx_reg) * PROD'(s0_sx_reg);
            s1_ssy_reg <= PROD'(s0_sy_reg) * PROD'(s0_sy_reg);
            s1_rr_reg  <= (2*RADW)'(s0_r_reg) * (2*RADW)'(s0_r_reg);
            s1_x0_reg  <= s0_x0_reg;
            s1_y0_reg  <= s0_y0_reg;
            s1_dx_reg  <= s0_dx_reg;
            s1_dy_reg  <= s0_dy_reg;
        end
    end

    // stage 2: quadratic coefficients
    sq_side_t               s2_side_reg;
    logic signed [CWID-1:0] s2_c_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_side_reg.x0    <= s1_x0_reg;
            s2_side_reg.y0    <= s1_y0_reg;
            s2_side_reg.dx    <= s1_dx_reg;
            s2_side_reg.dy    <= s1_dy_reg;
            s2_side_reg.a     <= SUMW'(s1_ddx_reg + s1_ddy_reg);
            s2_side_reg.h     <= s1_dsx_reg + s1_dsy_reg;
            s2_side_reg.degen <= (s1_ddx_reg + s1_ddy_reg) == '0;
            s2_side_reg.neg   <= 1'b0;
            s2_c_reg <= CWID'(s1_ssx_reg) + CWID'(s1_ssy_reg)
                        - CWID'({1'b0, s1_rr_reg});
        end
    end

    // stage 3: partial products of h^2 and a*|c|
    logic [SUMW-1:0]        hmag, cmag;
    logic [SUMW:0]          hneg;
    logic [CWID-1:0]        cneg;
    logic [2*HALF-1:0]      s3_hhh_reg, s3_hhl_reg, s3_hll_reg;
    logic [2*HALF-1:0]      s3_ahh_reg, s3_ahl_reg, s3_alh_reg, s3_all_reg;
    logic                   s3_cs_reg;
    sq_side_t               s3_side_reg;

    assign hneg = {1'b0, ~s2_side_reg.h} + (SUMW+1)'(1);
    assign cneg = ~s2_c_reg + CWID'(1);
    assign hmag = s2_side_reg.h[SUMW-1] ? hneg[SUMW-1:0] : s2_side_reg.h;
    assign cmag = s2_c_reg[CWID-1] ? cneg[SUMW-1:0] : s2_c_reg[SUMW-1:0];

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_hhh_reg  <= (2*HALF)'(hmag[SUMW-1:HALF]) * (2*HALF)'(hmag[SUMW-1:HALF]);
            s3_hhl_reg  <= (2*HALF)'(hmag[SUMW-1:HALF]) * (2*HALF)'(hmag[HALF-1:0]);
            s3_hll_reg  <= (2*HALF)'(hmag[HALF-1:0]) * (2*HALF)'(hmag[HALF-1:0]);
            s3_ahh_reg  <= (2*HALF)'(s2_side_reg.a[SUMW-1:HALF])
                           * (2*HALF)'(cmag[SUMW-1:HALF]);
            s3_ahl_reg  <= (2*HALF)'(s2_side_reg.a[SUMW-1:HALF])
                           * (2*HALF)'(cmag[HALF-1:0]);
            s3_alh_reg  <= (2*HALF)'(s2_side_reg.a[HALF-1:0])
                           * (2*HALF)'(cmag[SUMW-1:HALF]);
            s3_all_reg  <= (2*HALF)'(s2_side_reg.a[HALF-1:0])
                           * (2*HALF)'(cmag[HALF-1:0]);
            s3_cs_reg   <= s2_c_reg[CWID-1];
            s3_side_reg <= s2_side_reg;
        end
    end

    // stage 4: assemble h^2 and a*|c|
    logic [DW2-1:0] s4_h2_reg, s4_ac_reg;
    logic           s4_cs_reg;
    sq_side_t       s4_side_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_h2_reg <= (DW2'(s3_hhh_reg) << (2*HALF)) + (DW2'(s3_hhl_reg) << (HALF+1))
                         + DW2'(s3_hll_reg);
            s4_ac_reg <= (DW2'(s3_ahh_reg) << (2*HALF))
                         + ((DW2'(s3_ahl_reg) + DW2'(s3_alh_reg)) << HALF)
                         + DW2'(s3_all_reg);
            s4_cs_reg   <= s3_cs_reg;
            s4_side_reg <= s3_side_reg;
        end
    end

    // stage 5: quarter discriminant
    logic [DISW-1:0] disc;
    logic [DW2-1:0]  s5_rad_reg;
    sq_side_t        s5_side_reg;
    sq_side_t        s5_side_next;

    assign disc = s4_cs_reg ? DISW'(s4_h2_reg) + DISW'(s4_ac_reg)
                            : DISW'(s4_h2_reg) - DISW'(s4_ac_reg);

    always_comb
    begin
        s5_side_next     = s4_side_reg;
        s5_side_next.neg = disc[DISW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_rad_reg  <= disc[DISW-1] ? '0 : disc[DW2-1:0];
            s5_side_reg <= s5_side_next;
        end
    end

    logic [SQN-1:0] root;
    sq_side_t       sq_side;

    lsci_sqrt u_sqrt (
        .clk      (clk),
        .en       (en[ST_SQ0 +: SQN]),
        .rad      (s5_rad_reg),
        .side_in  (s5_side_reg),
        .root     (root),
        .side_out (sq_side)
    );

    // numerators of both roots and their range checks
    logic signed [NW-1:0] hx, n1, n2;
    logic [NW-1:0]        n1neg, n2neg;
    logic [NMAG-1:0]      n_mag_reg [2];
    logic [1:0]           n_sgn_reg;
    logic signed [DW-1:0] sn_dx_reg, sn_dy_reg;
    div_side_t            sn_side_reg;

    assign hx    = {{(NW-SUMW){sq_side.h[SUMW-1]}}, sq_side.h};
    assign n1    = {{(NW-SQN){1'b0}}, root} - hx;
    assign n2    = -hx - {{(NW-SQN){1'b0}}, root};
    assign n1neg = ~n1 + NW'(1);
    assign n2neg = ~n2 + NW'(1);

    always_ff @(posedge clk)
    begin
        if (en[ST_N])
        begin
            n_mag_reg[0]      <= n1[NW-1] ? n1neg[NMAG-1:0] : n1[NMAG-1:0];
            n_mag_reg[1]      <= n2[NW-1] ? n2neg[NMAG-1:0] : n2[NMAG-1:0];
            n_sgn_reg         <= {n2[NW-1], n1[NW-1]};
            sn_dx_reg         <= sq_side.dx;
            sn_dy_reg         <= sq_side.dy;
            sn_side_reg.x0    <= sq_side.x0;
            sn_side_reg.y0    <= sq_side.y0;
            sn_side_reg.a     <= sq_side.a;
            sn_side_reg.sgn   <= '0;
            sn_side_reg.v1    <= !n1[NW-1] && (n1 <= {{(NW-SUMW){1'b0}}, sq_side.a});
            sn_side_reg.v2    <= !n2[NW-1] && (n2 <= {{(NW-SUMW){1'b0}}, sq_side.a});
            sn_side_reg.degen <= sq_side.degen;
            sn_side_reg.neg   <= sq_side.neg;
        end
    end

    // d * n as two partial products per lane
    logic [DW-1:0]      dxneg, dyneg, dxmag, dymag;
    logic [DW+NLO-1:0]  pp_lo_reg [NLANE];
    logic [DW+NHI-1:0]  pp_hi_reg [NLANE];
    div_side_t          pp_side_reg;
    div_side_t          pp_side_next;

    assign dxneg = ~sn_dx_reg + DW'(1);
    assign dyneg = ~sn_dy_reg + DW'(1);
    assign dxmag = sn_dx_reg[DW-1] ? dxneg : sn_dx_reg;
    assign dymag = sn_dy_reg[DW-1] ? dyneg : sn_dy_reg;

    always_comb
    begin
        pp_side_next     = sn_side_reg;
        pp_side_next.sgn = {sn_dy_reg[DW-1] ^ n_sgn_reg[1], sn_dx_reg[DW-1] ^ n_sgn_reg[1],
                            sn_dy_reg[DW-1] ^ n_sgn_reg[0], sn_dx_reg[DW-1] ^ n_sgn_reg[0]};
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_N+1])
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                pp_lo_reg[l] <= (DW+NLO)'(l[0] ? dymag : dxmag)
                                * (DW+NLO)'(n_mag_reg[l/2][NLO-1:0]);
                pp_hi_reg[l] <= (DW+NHI)'(l[0] ? dymag : dxmag)
                                * (DW+NHI)'(n_mag_reg[l/2][NMAG-1:NLO]);
            end
            pp_side_reg <= pp_side_next;
        end
    end

    logic [MW-1:0] p_reg [NLANE];
    div_side_t     p_side_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_N+2])
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                p_reg[l] <= MW'(pp_lo_reg[l]) + (MW'(pp_hi_reg[l]) << NLO);
            end
            p_side_reg <= pp_side_reg;
        end
    end

    // add half the divisor for round to nearest
    logic [MW-1:0] m_reg [NLANE];
    div_side_t     m_side_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_N+3])
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                m_reg[l] <= p_reg[l] + MW'(p_side_reg.a >> 1);
            end
            m_side_reg <= p_side_reg;
        end
    end

    logic [QB-1:0] quo [NLANE];
    div_side_t     dv_side;

    lsci_div u_div (
        .clk      (clk),
        .en       (en[ST_DIV0 +: QB]),
        .m        (m_reg),
        .side_in  (m_side_reg),
        .quo      (quo),
        .side_out (dv_side)
    );

    // signed quotient plus start point, saturated to coordinate range
    logic signed [CW-1:0] coord [NLANE];

    always_comb
    begin
        logic signed [QSW-1:0] sq;
        logic signed [SSW-1:0] sum;
        logic signed [CW-1:0]  base;
        logic signed [SSW-1:0] lim_hi;
        logic signed [SSW-1:0] lim_lo;
        lim_hi = SSW'($signed({1'b0, {(CW-1){1'b1}}}));
        lim_lo = SSW'($signed({1'b1, {(CW-1){1'b0}}}));
        for (int l = 0; l < NLANE; l++)
        begin
            sq   = dv_side.sgn[l] ? -$signed({1'b0, quo[l]}) : $signed({1'b0, quo[l]});
            base = l[0] ? dv_side.y0 : dv_side.x0;
            sum  = SSW'(base) + SSW'(sq);
            if (sum > lim_hi)
            begin
                coord[l] = {1'b0, {(CW-1){1'b1}}};
            end
            else if (sum < lim_lo)
            begin
                coord[l] = {1'b1, {(CW-1){1'b0}}};
            end
            else
            begin
                coord[l] = sum[CW-1:0];
            end
        end
    end

    logic                 first_valid_reg, second_valid_reg, degenerate_reg;
    logic signed [CW-1:0] first_x_reg, first_y_reg, second_x_reg, second_y_reg;
    logic                 keep;

    assign keep = !dv_side.degen && !dv_side.neg;

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            degenerate_reg   <= dv_side.degen;
            first_valid_reg  <= keep && dv_side.v1;
            second_valid_reg <= keep && dv_side.v2;
            first_x_reg      <= keep ? coord[0] : '0;
            first_y_reg      <= keep ? coord[1] : '0;
            second_x_reg     <= keep ? coord[2] : '0;
            second_y_reg     <= keep ? coord[3] : '0;
        end
    end

    assign first_valid  = first_valid_reg;
    assign first_x      = first_x_reg;
    assign first_y      = first_y_reg;
    assign second_valid = second_valid_reg;
    assign second_x     = second_x_reg;
    assign second_y     = second_y_reg;
    assign degenerate   = degenerate_reg;

    ap_degen_no_points: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && degenerate |-> !first_valid && !second_valid
                                       && first_x == '0 && second_y == '0)
        else $error("degenerate result carries points");

    ap_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg == '0 |-> item_ready)
        else $error("empty pipe refuses input");

    ap_enter: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> v_reg[0])
        else $error("accepted transfer lost at first stage");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the segment/circle crossing pipe against a wide-integer predictor of
// the quadratic, root and rounded point maths. Random gaps on both channels,
// a long result stall that fills the pipe, and a drain pause between phases.
// ----------------------------------------------------------------------------
module tb
    import lsci_pkg::*;
();

    typedef struct {
        logic signed [CW-1:0] sx, sy, ex, ey, cx, cy;
        logic [RADW-1:0]      r;
    } seg_item_t;

    typedef struct {
        logic                 v1;
        logic signed [CW-1:0] x1, y1;
        logic                 v2;
        logic signed [CW-1:0] x2, y2;
        logic                 degen;
    } crossing_t;

    typedef logic signed [255:0] wide_t;
    typedef logic [255:0]        uwide_t;

    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_ready;
    logic signed [CW-1:0] seg_start_x, seg_start_y, seg_end_x, seg_end_y;
    logic signed [CW-1:0] center_x, center_y;
    logic [RADW-1:0]      radius;
    logic                 result_valid;
    logic                 result_ready;
    logic                 first_valid, second_valid, degenerate;
    logic signed [CW-1:0] first_x, first_y, second_x, second_y;

    seg_item_t pending_items[$];
    crossing_t expected_crossings[$];
    seg_item_t driven_item;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  send_hold = 0;
    int  stall_seq = 0;
    int  stall_seen = 0;
    int  stall_left = 0;
    int  mismatches = 0;
    int  results_seen = 0;
    int  hits_seen = 0;
    int  degen_seen = 0;

    line_segment_circle_intersect u_dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready),
        .seg_start_x(seg_start_x), .seg_start_y(seg_start_y),
        .seg_end_x(seg_end_x), .seg_end_y(seg_end_y),
        .center_x(center_x), .center_y(center_y), .radius(radius),
        .result_valid(result_valid), .result_ready(result_ready),
        .first_valid(first_valid), .first_x(first_x), .first_y(first_y),
        .second_valid(second_valid), .second_x(second_x), .second_y(second_y),
        .degenerate(degenerate)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic uwide_t floor_sqrt(uwide_t n);
        uwide_t root;
        uwide_t probe;
        root  = '0;
        probe = uwide_t'(1) << 254;
        while (probe > n)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (n >= root + probe)
            begin
                n    = n - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return root;
    endfunction

    // nearest, ties away from zero; den > 0
    function automatic wide_t round_div(wide_t num, wide_t den);
        uwide_t mag;
        uwide_t quo;
        mag = num < 0 ? uwide_t'(-num) : uwide_t'(num);
        quo = (mag + (uwide_t'(den) >> 1)) / uwide_t'(den);
        return num < 0 ? -wide_t'(quo) : wide_t'(quo);
    endfunction

    function automatic logic signed [CW-1:0] clamp_coord(wide_t v);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (CW - 1)) - 1;
        lo = -(wide_t'(1) <<< (CW - 1));
        if (v > hi)
            return hi[CW-1:0];
        if (v < lo)
            return lo[CW-1:0];
        return v[CW-1:0];
    endfunction

    function automatic crossing_t predict_crossing(seg_item_t it);
        crossing_t res;
        wide_t x0, y0, ox, oy, dx, dy, rr, a, h, c, disc, q, n1, n2;
        res = '{default: '0};
        x0  = wide_t'(it.sx);
        y0  = wide_t'(it.sy);
        ox  = x0 - wide_t'(it.cx);
        oy  = y0 - wide_t'(it.cy);
        dx  = wide_t'(it.ex) - x0;
        dy  = wide_t'(it.ey) - y0;
        rr  = wide_t'({1'b0, it.r});
        a   = dx * dx + dy * dy;
        if (a == 0)
        begin
            res.degen = 1'b1;
            return res;
        end
        h    = dx * ox + dy * oy;
        c    = ox * ox + oy * oy - rr * rr;
        disc = h * h - a * c;
        if (disc < 0)
            return res;
        q  = wide_t'(floor_sqrt(uwide_t'(disc)));
        n1 = q - h;
        n2 = -h - q;
        res.v1 = n1 >= 0 && n1 <= a;
        res.x1 = clamp_coord(x0 + round_div(dx * n1, a));
        res.y1 = clamp_coord(y0 + round_div(dy * n1, a));
        res.v2 = n2 >= 0 && n2 <= a;
        res.x2 = clamp_coord(x0 + round_div(dx * n2, a));
        res.y2 = clamp_coord(y0 + round_div(dy * n2, a));
        return res;
    endfunction

    function automatic void add_item(seg_item_t it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid  <= 1'b0;
            driven_item <= '{default: '0};
            seg_start_x <= '0;
            seg_start_y <= '0;
            seg_end_x   <= '0;
            seg_end_y   <= '0;
            center_x    <= '0;
            center_y    <= '0;
            radius      <= '0;
        end
        else
        begin
            if (item_valid && item_ready)
                expected_crossings.insert(expected_crossings.size(),
                                          predict_crossing(driven_item));
            if (!item_valid || item_ready)
            begin
                if (pending_items.size() > 0 && !send_hold &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    seg_item_t nxt;
                    nxt = pending_items.pop_front();
                    driven_item <= nxt;
                    seg_start_x <= nxt.sx;
                    seg_start_y <= nxt.sy;
                    seg_end_x   <= nxt.ex;
                    seg_end_y   <= nxt.ey;
                    center_x    <= nxt.cx;
                    center_y    <= nxt.cy;
                    radius      <= nxt.r;
                    item_valid  <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // long hold-off of the result side
    always @(posedge clk)
    begin
        if (stall_seq != stall_seen)
        begin
            stall_seen <= stall_seq;
            stall_left <= 400;
        end
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
            begin
                crossing_t want;
                results_seen++;
                if (expected_crossings.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result transfer with nothing expected", $realtime);
                end
                else
                begin
                    want = expected_crossings.pop_front();
                    if (want.v1 || want.v2)
                        hits_seen++;
                    if (want.degen)
                        degen_seen++;
                    if (first_valid !== want.v1 || first_x !== want.x1 ||
                        first_y !== want.y1 || second_valid !== want.v2 ||
                        second_x !== want.x2 || second_y !== want.y2 ||
                        degenerate !== want.degen)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: exp %b %0d %0d %b %0d %0d %b",
                                      " got %b %0d %0d %b %0d %0d %b"},
                                $realtime, want.v1, want.x1, want.y1, want.v2, want.x2,
                                want.y2, want.degen, first_valid, first_x, first_y,
                                second_valid, second_x, second_y, degenerate);
                    end
                end
            end
            result_ready <= stall_left == 0 && $urandom_range(99) >= recv_stall_pct;
        end
    end

    function automatic seg_item_t mk_item(int sx, int sy, int ex, int ey,
                                          int cx, int cy, int r);
        seg_item_t it;
        it.sx = sx;
        it.sy = sy;
        it.ex = ex;
        it.ey = ey;
        it.cx = cx;
        it.cy = cy;
        it.r  = r[RADW-1:0];
        return it;
    endfunction

    function automatic int span(int lim);
        return int'($urandom_range(2 * lim)) - lim;
    endfunction

    function automatic seg_item_t random_item();
        seg_item_t it;
        int kind;
        int lim;
        int cx, cy, rad;
        kind = $urandom_range(9);
        lim  = 1 << $urandom_range(8, 24);
        cx   = span(lim);
        cy   = span(lim);
        rad  = $urandom_range(1, lim);
        it   = mk_item(cx + span(2 * rad), cy + span(2 * rad), cx + span(2 * rad),
                       cy + span(2 * rad), cx, cy, rad);
        case (kind)
            0:
            begin
                it.sx = $urandom;  it.sy = $urandom;  it.ex = $urandom;
                it.ey = $urandom;  it.cx = $urandom;  it.cy = $urandom;
                it.r  = RADW'($urandom);
            end
            1:
            begin
                it.ex = it.sx;
                it.ey = it.sy;
            end
            2:
            begin
                // chord through the circle, one end inside
                it.sx = cx + span(rad / 2);
                it.sy = cy + span(rad / 2);
            end
            3:
            begin
                // horizontal tangent
                it.sy = cy + rad;
                it.ey = cy + rad;
                it.sx = cx - rad - $urandom_range(lim);
                it.ex = cx + rad + $urandom_range(lim);
            end
            4:
                it.r = RADW'($urandom);
            default: ;
        endcase
        return it;
    endfunction

    task automatic drain_all();
        wait (pending_items.size() == 0);
        @(posedge clk);
        while (item_valid || expected_crossings.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int idle_sets[4][2];
        int big;
        big = 32'h7fffffff;
        idle_sets = '{'{0, 0}, '{65, 0}, '{0, 65}, '{27, 27}};
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        add_item(mk_item(0, 0, 0, 0, 0, 0, 0));
        add_item(mk_item(big, -big - 1, big, -big - 1, 5, 5, 100));
        add_item(mk_item(-10 << 16, 5 << 16, 10 << 16, 5 << 16, 0, 0, 5 << 16));
        add_item(mk_item(-10 << 16, 0, 10 << 16, 0, 0, 0, 3 << 16));
        add_item(mk_item(-10 << 16, 0, 10 << 16, 0, 0, 100 << 16, 1 << 16));
        add_item(mk_item(0, 0, 1 << 16, 0, 20 << 16, 0, 2 << 16));
        add_item(mk_item(0, 0, 4 << 16, 0, 0, 0, 0));
        add_item(mk_item(0, 0, 3 << 16, 4 << 16, 0, 0, 5 << 16));
        add_item(mk_item(-big - 1, -big - 1, big, big, 0, 0, big));
        add_item(mk_item(big, big, -big - 1, -big - 1, -big - 1, big, big));
        add_item(mk_item(-big - 1, big, big, -big - 1, big, big, big));
        add_item(mk_item(0, 0, 1, 0, 0, 0, big));
        add_item(mk_item(-1, -1, 1, 1, 0, 0, 1));
        add_item(mk_item(big, 0, big - 1, 0, -big - 1, 0, big));
        add_item(mk_item(1, 1, 2, 2, big, big, 0));
        drain_all();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = idle_sets[ph][0];
            recv_stall_pct = idle_sets[ph][1];
            if (ph == 1)
            begin
                // sender pauses until the pipe has emptied
                send_hold = 1'b1;
                drain_all();
                send_hold = 1'b0;
            end
            for (int i = 0; i < 220; i++)
                add_item(random_item());
            if (ph == 0)
                stall_seq++;
            drain_all();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 200; i++)
            add_item(random_item());
        stall_seq++;
        drain_all();
        repeat (150) @(posedge clk);

        $display("Ran %0d results: %0d with a crossing on the segment, %0d degenerate.",
                 results_seen, hits_seen, degen_seen);
        $display("Idle mixes on both channels, long result hold-off, drain pauses; %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && expected_crossings.size() == 0)
            $display("line_segment_circle_intersect test passed");
        else
            $display("line_segment_circle_intersect test failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("line_segment_circle_intersect test failed");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/lsci_pkg.sv
hw/rtl/lsci_sqrt.sv
hw/rtl/lsci_div.sv
hw/rtl/line_segment_circle_intersect.sv
test/tb.sv
